// ----- rtl/x86oc_pkg.sv -----
// ----------------------------------------------------------------------------
// x86oc_pkg: shared types, constants and match functions
// Byte constants, jump fold table and nop pattern checks for the
// opcode canonicalizer.
// ----------------------------------------------------------------------------
package x86oc_pkg;

  localparam int unsigned WinLen  = 8;
  // Bytes seen from the (possibly REX-shifted) opcode position.
  localparam int unsigned ViewLen = WinLen - 1;

  typedef logic [WinLen-1:0][7:0]  win_t;
  typedef logic [ViewLen-1:0][7:0] view_t;

  localparam logic [7:0] OpRexLo  = 8'h40;
  localparam logic [7:0] OpIncEax = 8'h40;
  localparam logic [7:0] OpDecEax = 8'h48;
  localparam logic [7:0] OpPushEax = 8'h50;
  localparam logic [7:0] OpPopEax  = 8'h58;
  localparam logic [7:0] OpOpsize = 8'h66;
  localparam logic [7:0] OpEscape = 8'h0F;
  localparam logic [7:0] OpRep    = 8'hF3;
  localparam logic [7:0] OpRepne  = 8'hF2;
  localparam logic [7:0] OpNop    = 8'h90;
  localparam logic [7:0] OpLea    = 8'h8D;
  localparam logic [7:0] NearJccBias = 8'h10;
  localparam logic [7:0] SibEsp   = 8'h24;
  localparam logic [7:0] SibEspAlt = 8'h26;

  // Odd condition codes fold onto an even partner code (75/71/7B/79 onto their negation).
  function automatic logic [7:0] fold_jump(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h77:   r = 8'h72;
      8'h73:   r = 8'h76;
      8'h75:   r = 8'h74;
      8'h7F:   r = 8'h7C;
      8'h7D:   r = 8'h7E;
      8'h71:   r = 8'h70;
      8'h7B:   r = 8'h7A;
      8'h79:   r = 8'h78;
      default: r = c;
    endcase
    return r;
  endfunction

  // lea reg, [reg + 0] in its various encodings.
  function automatic logic lea_is_nop(input view_t v);
    logic r;
    logic z8;
    logic z32_at2;
    logic z32_at3;
    z8      = (v[2] == 8'h00);
    z32_at2 = ({v[5], v[4], v[3], v[2]} == 32'h0);
    z32_at3 = ({v[6], v[5], v[4], v[3]} == 32'h0);
    unique case (v[1])
      8'h00, 8'h09, 8'h42, 8'h4B, 8'h36, 8'h3F:        r = 1'b1;
      8'h40, 8'h49, 8'h52, 8'h5B, 8'h6D, 8'h76, 8'h7F: r = z8;
      8'h80, 8'h89, 8'h92, 8'h9B, 8'hAD, 8'hB6, 8'hBF: r = z32_at2;
      8'hB4:   r = (v[2] == SibEspAlt) && z32_at3;
      8'h24:   r = (v[2] == SibEsp);
      8'h64:   r = (v[2] == SibEsp) && (v[3] == 8'h00);
      8'hA4:   r = (v[2] == SibEsp) && z32_at3;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // nop, self mov/xchg, zero-offset lea.
  function automatic logic is_nop(input view_t v);
    logic mov_like;
    logic self_modrm;
    mov_like = (v[0] == 8'h8A) || (v[0] == 8'h8B) ||
               (v[0] == 8'h87) || (v[0] == 8'h86);
    self_modrm = (v[1] == 8'hC0) || (v[1] == 8'hC9) || (v[1] == 8'hDB) ||
                 (v[1] == 8'hD2) || (v[1] == 8'hF6) || (v[1] == 8'hFF) ||
                 (v[1] == 8'hE4) || (v[1] == 8'hED);
    return (mov_like && self_modrm) ||
           ((v[0] == OpLea) && lea_is_nop(v)) ||
           (v[0] == OpNop);
  endfunction

endpackage

// ----- rtl/x86_opcode_canonicalizer_top.sv -----
// ----------------------------------------------------------------------------
// x86_opcode_canonicalizer_top: x86 opcode canonicalizer
// Input beat to result beat: input reg, then result reg.
// Throughput: one instruction window per cycle while the consumer does not stall.
// The match logic between the two registers is a single pass of byte
// compares; the result register holds its beat while the consumer stalls.
// Reset: asynchronous active-low; clears both valid flags and long_mode.
// ----------------------------------------------------------------------------
module x86_opcode_canonicalizer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] win_byte0_i,
  input  logic [7:0] win_byte1_i,
  input  logic [7:0] win_byte2_i,
  input  logic [7:0] win_byte3_i,
  input  logic [7:0] win_byte4_i,
  input  logic [7:0] win_byte5_i,
  input  logic [7:0] win_byte6_i,
  input  logic [7:0] win_byte7_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] canon_opcode_o,
  output logic       ignorable_o,
  output logic       cond_jump_folded_o
);
  import x86oc_pkg::*;

  // Control state
  logic long_mode_q;
  logic s1_valid_q;
  logic out_valid_q;

  // Payload registers
  win_t       win_q;
  logic [7:0] canon_q;
  logic       ign_q;
  logic       jmp_q;

  // Handshake: each stage can take a beat when empty or when it drains.
  logic out_ready_int;
  logic s1_ready;
  logic in_fire;
  logic s1_fire;

  assign out_ready_int = !out_valid_q || out_ready_i;
  assign s1_ready      = !s1_valid_q || out_ready_int;
  assign in_ready_o    = s1_ready;
  assign in_fire       = in_valid_i && s1_ready;
  assign s1_fire       = s1_valid_q && out_ready_int;

  // --------------------------------------------------------------------------
  // Match logic on the registered window
  // --------------------------------------------------------------------------
  logic       rex_skip;
  view_t      view;
  logic [7:0] op_grp;
  logic [7:0] op_rep;
  logic [7:0] probe;
  logic       probe_jcc;
  logic [7:0] canon_d;
  logic       ign_d;
  logic       jmp_d;

  // In 64-bit mode a leading 40-4F is REX; the opcode moves to offset 1.
  assign rex_skip = long_mode_q && (win_q[0][7:4] == OpRexLo[7:4]);

  always_comb begin
    for (int i = 0; i < ViewLen; i++) begin
      view[i] = rex_skip ? win_q[i+1] : win_q[i];
    end
  end

  // Register-encoded push/pop/inc/dec fold to the eax form.
  always_comb begin
    priority case (view[0][7:3])
      OpPushEax[7:3]: op_grp = OpPushEax;
      OpPopEax[7:3]:  op_grp = OpPopEax;
      OpIncEax[7:3]:  op_grp = OpIncEax;
      OpDecEax[7:3]:  op_grp = OpDecEax;
      default:        op_grp = view[0];
    endcase
  end

  // 66 F3 / 66 F2 take the rep byte as the opcode.
  assign op_rep = ((op_grp == OpOpsize) &&
                   ((view[1] == OpRep) || (view[1] == OpRepne))) ? view[1] : op_grp;

  // Near Jcc (0F 8x) probes as its short form 7x.
  assign probe     = (op_rep == OpEscape) ? (view[1] - NearJccBias) : op_rep;
  assign probe_jcc = (probe[7:4] == 4'h7);

  assign canon_d = probe_jcc ? fold_jump(probe) : op_rep;
  assign jmp_d   = probe_jcc;
  assign ign_d   = is_nop(view);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        long_mode_q <= cfg_wdata_i;
      end
      if (s1_ready) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_ready_int) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      win_q <= {win_byte7_i, win_byte6_i, win_byte5_i, win_byte4_i,
                win_byte3_i, win_byte2_i, win_byte1_i, win_byte0_i};
    end
    if (s1_fire) begin
      canon_q <= canon_d;
      ign_q   <= ign_d;
      jmp_q   <= jmp_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign canon_opcode_o     = canon_q;
  assign ignorable_o        = ign_q;
  assign cond_jump_folded_o = jmp_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A folded jump always comes out as a short Jcc code.
  a_jcc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cond_jump_folded_o |-> canon_opcode_o[7:4] == 4'h7)
    else $error("folded jump outside 70-7F");

  // Codes in the fold table never leave the block unfolded.
  a_jcc_folded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cond_jump_folded_o |->
      canon_opcode_o != 8'h77 && canon_opcode_o != 8'h73 &&
      canon_opcode_o != 8'h75 && canon_opcode_o != 8'h7F &&
      canon_opcode_o != 8'h7D && canon_opcode_o != 8'h71 &&
      canon_opcode_o != 8'h7B && canon_opcode_o != 8'h79)
    else $error("negated condition not folded");

  // An accepted beat lands in the input stage.
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted beat lost");

  // With both stages full and a stall, nothing new may enter.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i && s1_valid_q |-> !in_ready_o)
    else $error("input stage overrun");

endmodule
